>>> src/anrp_pkg.sv
// Shared types and constants for the ASCII number range parser.
// No dependencies; every other file of the block imports this package.
package anrp_pkg;

    localparam int CharWidth = 8;
    localparam int ValWidth  = 8;
    localparam int PhWidth   = 3;

    // Parser phase codes.
    localparam logic [PhWidth-1:0] PH_ARG_START  = 3'd0;
    localparam logic [PhWidth-1:0] PH_NUM_START  = 3'd1;
    localparam logic [PhWidth-1:0] PH_AFTER_SIGN = 3'd2;
    localparam logic [PhWidth-1:0] PH_ZERO       = 3'd3;
    localparam logic [PhWidth-1:0] PH_DEC        = 3'd4;
    localparam logic [PhWidth-1:0] PH_HEX        = 3'd5;
    localparam logic [PhWidth-1:0] PH_DONE       = 3'd6;

    // Character codes the parser reacts to.
    localparam logic [CharWidth-1:0] CH_STAR  = 8'h2A;
    localparam logic [CharWidth-1:0] CH_DASH  = 8'h2D;
    localparam logic [CharWidth-1:0] CH_ZERO  = 8'h30;
    localparam logic [CharWidth-1:0] CH_NINE  = 8'h39;
    localparam logic [CharWidth-1:0] CH_UP_A  = 8'h41;
    localparam logic [CharWidth-1:0] CH_UP_F  = 8'h46;
    localparam logic [CharWidth-1:0] CH_LO_A  = 8'h61;
    localparam logic [CharWidth-1:0] CH_LO_F  = 8'h66;
    localparam logic [CharWidth-1:0] CH_LO_X  = 8'h78;

    localparam logic [ValWidth-1:0] FULL_HIGH = 8'd255;

    // Decoded properties of one character.
    typedef struct packed {
        logic       is_star;
        logic       is_dash;
        logic       is_zero;
        logic       is_x;
        logic       is_dig;
        logic       is_hex;
        logic [3:0] nibble;   // digit or hex value, valid when is_hex
    } t_char_class;

    // Complete parser state carried from beat to beat.
    typedef struct packed {
        logic [PhWidth-1:0]  phase;
        logic                second;
        logic                neg;
        logic [ValWidth-1:0] acc;
        logic [ValWidth-1:0] first;
        logic                wild;
    } t_parse_state;

    localparam t_parse_state STATE_RESET = '{
        phase:  PH_ARG_START,
        second: 1'b0,
        neg:    1'b0,
        acc:    '0,
        first:  '0,
        wild:   1'b0
    };

endpackage

>>> src/anrp_char_class.sv
// Character decoder for the range parser: flags and digit value of one byte.
// Depends on anrp_pkg.
module anrp_char_class
    import anrp_pkg::*;
(
    input  logic [CharWidth-1:0] i_char,
    output t_char_class          o_class
);

    logic w_dig;
    logic w_up;
    logic w_lo;

    assign w_dig = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign w_up  = (i_char >= CH_UP_A) && (i_char <= CH_UP_F);
    assign w_lo  = (i_char >= CH_LO_A) && (i_char <= CH_LO_F);

    always_comb begin
        o_class.is_star = (i_char == CH_STAR);
        o_class.is_dash = (i_char == CH_DASH);
        o_class.is_zero = (i_char == CH_ZERO);
        o_class.is_x    = (i_char == CH_LO_X);
        o_class.is_dig  = w_dig;
        o_class.is_hex  = w_dig || w_up || w_lo;
        // Letters A..F and a..f share their low nibble 1..6; add 9 for 10..15.
        if (w_dig) begin
            o_class.nibble = i_char[3:0];
        end else begin
            o_class.nibble = i_char[3:0] + 4'd9;
        end
    end

endmodule

>>> src/anrp_step.sv
// Next-state and result logic of the range parser for one beat.
// Depends on anrp_pkg and anrp_char_class.
module anrp_step
    import anrp_pkg::*;
(
    input  t_parse_state         i_state,
    input  logic [CharWidth-1:0] i_char,
    input  logic                 i_last,
    output t_parse_state         o_state,
    output logic [ValWidth-1:0]  o_low,
    output logic [ValWidth-1:0]  o_high,
    output logic                 o_wild
);

    t_char_class         w_cls;
    logic [ValWidth-1:0] w_signed_val;
    logic [ValWidth-1:0] w_dec_val;
    logic [ValWidth-1:0] w_hex_val;
    t_parse_state        w_fin;

    anrp_char_class u_class (
        .i_char  (i_char),
        .o_class (w_cls)
    );

    assign w_signed_val = i_state.neg ? (~i_state.acc + 8'd1) : i_state.acc;
    // acc * 10 + digit, modulo 256.
    assign w_dec_val = {i_state.acc[4:0], 3'b000} + {i_state.acc[6:0], 1'b0}
                       + {4'b0000, w_cls.nibble};
    assign w_hex_val = {i_state.acc[3:0], 4'b0000} + {4'b0000, w_cls.nibble};

    // Closing of the current number; a dash after the first number opens the second.
    function automatic t_parse_state end_number(input t_parse_state s,
                                                input logic [ValWidth-1:0] v,
                                                input logic dash);
        t_parse_state r;
        r = s;
        if (!s.second) begin
            r.first = v;
            if (dash) begin
                r.second = 1'b1;
                r.neg    = 1'b0;
                r.acc    = '0;
                r.phase  = PH_NUM_START;
            end else begin
                r.phase = PH_DONE;
            end
        end else begin
            r.acc   = v;
            r.phase = PH_DONE;
        end
        return r;
    endfunction

    // End of argument: an unfinished number is closed as if by a non-dash.
    always_comb begin
        if (i_state.phase != PH_DONE) begin
            w_fin = end_number(i_state, w_signed_val, 1'b0);
        end else begin
            w_fin = i_state;
        end
        if (i_state.wild) begin
            o_low  = '0;
            o_high = FULL_HIGH;
            o_wild = 1'b1;
        end else begin
            o_low  = w_fin.first;
            o_high = w_fin.second ? w_fin.acc : w_fin.first;
            o_wild = 1'b0;
        end
    end

    always_comb begin
        logic num_start;
        logic after_sign;
        logic dec_digits;
        num_start  = 1'b0;
        after_sign = 1'b0;
        dec_digits = 1'b0;
        o_state    = i_state;
        if (i_last) begin
            o_state = STATE_RESET;
        end else begin
            case (i_state.phase)
                PH_ARG_START: begin
                    if (w_cls.is_star) begin
                        o_state.wild  = 1'b1;
                        o_state.phase = PH_DONE;
                    end else begin
                        num_start = 1'b1;
                    end
                end
                PH_NUM_START:  num_start  = 1'b1;
                PH_AFTER_SIGN: after_sign = 1'b1;
                PH_ZERO: begin
                    if (w_cls.is_x) begin
                        o_state.acc   = '0;
                        o_state.phase = PH_HEX;
                    end else begin
                        dec_digits = 1'b1;
                    end
                end
                PH_DEC: dec_digits = 1'b1;
                PH_HEX: begin
                    if (w_cls.is_hex) begin
                        o_state.acc = w_hex_val;
                    end else begin
                        o_state = end_number(i_state, w_signed_val, w_cls.is_dash);
                    end
                end
                default: o_state = i_state;
            endcase

            if (num_start) begin
                if (w_cls.is_dash) begin
                    o_state.neg   = 1'b1;
                    o_state.phase = PH_AFTER_SIGN;
                end else begin
                    after_sign = 1'b1;
                end
            end

            if (after_sign) begin
                if (w_cls.is_zero) begin
                    o_state.acc   = '0;
                    o_state.phase = PH_ZERO;
                end else if (w_cls.is_dig) begin
                    o_state.acc   = {4'b0000, w_cls.nibble};
                    o_state.phase = PH_DEC;
                end else begin
                    o_state = end_number(i_state, w_signed_val, w_cls.is_dash);
                end
            end

            if (dec_digits) begin
                if (w_cls.is_dig) begin
                    o_state.acc   = w_dec_val;
                    o_state.phase = PH_DEC;
                end else begin
                    o_state = end_number(i_state, w_signed_val, w_cls.is_dash);
                end
            end
        end
    end

endmodule

>>> src/ascii_number_range_parser.sv
// Top level of the ASCII number range parser: stream ports and registers.
// Depends on anrp_pkg and anrp_step (which uses anrp_char_class).

// The block takes one character per beat on the slave stream and, on the beat
// that carries tlast, gives one result beat holding an 8-bit low and high
// bound. An argument starting with '*' yields 0..255 with the wildcard flag
// set. Otherwise it reads an optional '-', then "0x" and hex digits of either
// case, or decimal digits; a '-' after the first number starts a second one
// for the high bound, and anything after that is ignored. Values wrap modulo
// 256 and negatives come out in two's complement. The character on a tlast
// beat is ignored. A new beat is taken in every cycle unless a tlast beat is
// held back: each beat sits in an input register, and the parser state and
// result register are updated from it as it moves on. A full output register
// stalls only tlast beats; plain characters keep flowing while a result waits
// to be taken.
module ascii_number_range_parser
    import anrp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] character
    input  logic        s_axis_tlast,   // end_of_argument

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] range_low, [15:8] range_high
    output logic        m_axis_tuser    // is_wildcard
);

    // Input register.
    logic                 r_in_valid;
    logic [CharWidth-1:0] r_in_char;
    logic                 r_in_last;

    // Parser state.
    t_parse_state r_state;
    t_parse_state n_state;

    // Result register.
    logic                r_out_valid;
    logic [ValWidth-1:0] r_out_low;
    logic [ValWidth-1:0] r_out_high;
    logic                r_out_wild;
    logic [ValWidth-1:0] n_low;
    logic [ValWidth-1:0] n_high;
    logic                n_wild;

    logic w_advance;

    // The held beat moves on unless it is a tlast beat and the result slot
    // is still occupied.
    assign w_advance     = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    anrp_step u_step (
        .i_state (r_state),
        .i_char  (r_in_char),
        .i_last  (r_in_last),
        .o_state (n_state),
        .o_low   (n_low),
        .o_high  (n_high),
        .o_wild  (n_wild)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_last) begin
            r_out_low  <= n_low;
            r_out_high <= n_high;
            r_out_wild <= n_wild;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_high, r_out_low};
    assign m_axis_tuser  = r_out_wild;

endmodule

>>> sim/ascii_number_range_parser_tb.sv
`timescale 1ns / 100ps
// Testbench for ascii_number_range_parser: streams directed and random arguments
// and checks every result beat against a behavioral range predictor.
// Depends on anrp_pkg and on the RTL of the block.
module ascii_number_range_parser_tb;
    import anrp_pkg::*;

    localparam int CYCLE_LIMIT      = 500000;
    localparam int RANDOM_ARG_BEATS = 1100;
    localparam int NOISE_BEATS      = 250;
    localparam int DRAIN_CYCLES     = 20;

    // Characters the block has no constant for, used to build junk.
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam string HEX_SYMBOLS   = "0123456789abcdefABCDEF";
    localparam string JUNK_SYMBOLS  = "*-xX0 ,g9";

    typedef struct packed {
        logic [7:0] lo;
        logic [7:0] hi;
        logic       wild;
    } t_range;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] character
    logic        s_axis_tlast;   // end_of_argument
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [7:0] range_low, [15:8] range_high
    logic        m_axis_tuser;   // is_wildcard

    t_range      expected_ranges[$];
    logic [7:0]  arg_chars[$];
    int          mismatch_count = 0;
    int          beats_sent     = 0;
    bit          src_no_idle    = 1'b0;
    bit          sink_no_stall  = 1'b0;

    // Predictor copy of the parser state.
    logic [PhWidth-1:0] pr_phase;
    logic               pr_on_high;
    logic               pr_neg;
    logic [7:0]         pr_acc;
    logic [7:0]         pr_low;
    logic               pr_wild;

    ascii_number_range_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Range predictor
    // ------------------------------------------------------------------
    function automatic void clear_parse_state();
        pr_phase   = PH_ARG_START;
        pr_on_high = 1'b0;
        pr_neg     = 1'b0;
        pr_acc     = '0;
        pr_low     = '0;
        pr_wild    = 1'b0;
    endfunction

    // A non-digit closes the current number; a dash after the first number
    // opens the second one.
    function automatic void close_number(input logic [7:0] c);
        logic [7:0] v;
        v = pr_neg ? 8'd0 - pr_acc : pr_acc;
        if (!pr_on_high) begin
            pr_low = v;
            if (c == CH_DASH) begin
                pr_on_high = 1'b1;
                pr_neg     = 1'b0;
                pr_acc     = '0;
                pr_phase   = PH_NUM_START;
            end else begin
                pr_phase = PH_DONE;
            end
        end else begin
            pr_acc   = v;
            pr_phase = PH_DONE;
        end
    endfunction

    function automatic void take_char(input logic [7:0] c);
        logic       is_dig;
        logic       is_hex;
        logic [3:0] nib;
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
        is_hex = 1'b1;
        if (is_dig)
            nib = c[3:0];
        else if ((c >= CH_UP_A && c <= CH_UP_F) || (c >= CH_LO_A && c <= CH_LO_F))
            nib = c[3:0] + 4'd9;
        else begin
            nib    = 4'd0;
            is_hex = 1'b0;
        end
        case (pr_phase)
            PH_ARG_START, PH_NUM_START, PH_AFTER_SIGN: begin
                if (pr_phase == PH_ARG_START && c == CH_STAR) begin
                    pr_wild  = 1'b1;
                    pr_phase = PH_DONE;
                end else if (pr_phase != PH_AFTER_SIGN && c == CH_DASH) begin
                    pr_neg   = 1'b1;
                    pr_phase = PH_AFTER_SIGN;
                end else if (c == CH_ZERO) begin
                    pr_acc   = '0;
                    pr_phase = PH_ZERO;
                end else if (is_dig) begin
                    pr_acc   = {4'd0, nib};
                    pr_phase = PH_DEC;
                end else begin
                    close_number(c);
                end
            end
            PH_ZERO, PH_DEC: begin
                if (pr_phase == PH_ZERO && c == CH_LO_X) begin
                    pr_acc   = '0;
                    pr_phase = PH_HEX;
                end else if (is_dig) begin
                    pr_acc   = pr_acc * 8'd10 + {4'd0, nib};
                    pr_phase = PH_DEC;
                end else begin
                    close_number(c);
                end
            end
            PH_HEX: begin
                if (is_hex)
                    pr_acc = {pr_acc[3:0], nib};
                else
                    close_number(c);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void predict_beat(input logic [7:0] c, input logic last);
        t_range r;
        if (!last) begin
            take_char(c);
        end else begin
            if (pr_wild) begin
                r.lo   = 8'd0;
                r.hi   = FULL_HIGH;
                r.wild = 1'b1;
            end else begin
                if (pr_phase != PH_DONE)
                    close_number(CH_NUL);
                r.lo   = pr_low;
                r.hi   = pr_on_high ? pr_acc : pr_low;
                r.wild = 1'b0;
            end
            expected_ranges.push_back(r);
            clear_parse_state();
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_range want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_ranges.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, %s %0d high %0d wild %0b",
                         $time, "actual low", m_axis_tdata[7:0], m_axis_tdata[15:8],
                         m_axis_tuser);
                mismatch_count++;
            end else begin
                want = expected_ranges.pop_front();
                if (m_axis_tdata[7:0] !== want.lo) begin
                    $display("%0t: range_low mismatch, expected %0d actual %0d",
                             $time, want.lo, m_axis_tdata[7:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[15:8] !== want.hi) begin
                    $display("%0t: range_high mismatch, expected %0d actual %0d",
                             $time, want.hi, m_axis_tdata[15:8]);
                    mismatch_count++;
                end
                if (m_axis_tuser !== want.wild) begin
                    $display("%0t: is_wildcard mismatch, expected %0b actual %0b",
                             $time, want.wild, m_axis_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stream drivers
    // ------------------------------------------------------------------
    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // The result side alternates stall runs and ready runs.
    initial begin
        int stall;
        forever begin
            stall = sink_no_stall ? 0 : idle_len();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    // Offers one beat and returns on the edge that accepts it. Valid stays
    // high when the next beat follows without a gap.
    task automatic send_beat(input logic [7:0] c, input logic last);
        int gap;
        gap = src_no_idle ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_beat(c, last);
        beats_sent++;
    endtask

    task automatic send_string(input string s, input logic [7:0] end_char);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
        send_beat(end_char, 1'b1);
    endtask

    task automatic send_arg_chars();
        foreach (arg_chars[i])
            send_beat(arg_chars[i], 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [7:0] junk_char();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0)
            return CH_NUL;
        return JUNK_SYMBOLS[$urandom_range(0, JUNK_SYMBOLS.len() - 1)];
    endfunction

    // Appends one number: optional sign, then decimal, hex or "0X" form.
    task automatic add_number();
        int kind;
        if ($urandom_range(0, 3) == 0)
            arg_chars.push_back(CH_DASH);
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            repeat ($urandom_range(0, 4))
                arg_chars.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end else if (kind < 9) begin
            arg_chars.push_back(CH_ZERO);
            arg_chars.push_back(CH_LO_X);
            repeat ($urandom_range(0, 3))
                arg_chars.push_back(HEX_SYMBOLS[$urandom_range(0, HEX_SYMBOLS.len() - 1)]);
        end else begin
            arg_chars.push_back(CH_ZERO);
            arg_chars.push_back(CH_UP_X);
            arg_chars.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_wildcard_and_empty();
        send_string("*", 8'hFF);
        send_beat(8'h00, 1'b1);
    endtask

    task automatic test_signs_and_dashes();
        send_string("-x", 8'h00);    // sign with no digits
        send_string("--5", 8'hFF);   // dash right after the sign ends the first number
        send_string("5-*", 8'h2A);   // empty second number, star not first
    endtask

    task automatic test_hex_and_zero_char();
        send_string("0xFf-300", 8'h00);   // both hex cases, decimal overflow
        send_string("0X", 8'hFF);         // uppercase X is junk after a zero
        send_beat(8'h37, 1'b0);
        send_beat(CH_NUL, 1'b0);          // NUL character ends the number
        send_beat(8'h80, 1'b1);
    endtask

    task automatic test_random_arguments();
        int start;
        int r;
        start = beats_sent;
        while (beats_sent - start < RANDOM_ARG_BEATS) begin
            if ($urandom_range(0, 15) == 0) src_no_idle   = !src_no_idle;
            if ($urandom_range(0, 15) == 0) sink_no_stall = !sink_no_stall;
            arg_chars.delete();
            r = $urandom_range(0, 19);
            if (r == 0) begin
                arg_chars.push_back(CH_STAR);
                repeat ($urandom_range(0, 3)) arg_chars.push_back(junk_char());
            end else if (r < 17) begin
                add_number();
                if ($urandom_range(0, 1) == 1) begin
                    arg_chars.push_back(CH_DASH);
                    add_number();
                end
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 3)) arg_chars.push_back(junk_char());
            end else begin
                repeat ($urandom_range(0, 6)) arg_chars.push_back(junk_char());
            end
            send_arg_chars();
        end
        src_no_idle   = 1'b0;
        sink_no_stall = 1'b0;
    endtask

    // Fully random bytes with an end marker now and then.
    task automatic test_random_noise();
        int start;
        start = beats_sent;
        while (beats_sent - start < NOISE_BEATS)
            send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        clear_parse_state();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_wildcard_and_empty();
        test_signs_and_dashes();
        test_hex_and_zero_char();
        test_random_arguments();
        test_random_noise();
        s_axis_tvalid <= 1'b0;

        sink_no_stall = 1'b1;
        while (expected_ranges.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_ranges.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
